// File: sv/sc1kd_pkg.sv
// shared types, codes and character tables of the scan code set 1 key decoder
package sc1kd_pkg;

	localparam int unsigned KIND_W = 3;
	localparam int unsigned CHAR_W = 7;
	localparam int unsigned MODS_W = 7;

	localparam logic [KIND_W-1:0] KIND_NONE  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_CHAR  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_UP    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DOWN  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_LEFT  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_RIGHT = 3'd5;

	localparam int unsigned MB_LSHIFT = 0;
	localparam int unsigned MB_RSHIFT = 1;
	localparam int unsigned MB_LCTRL  = 2;
	localparam int unsigned MB_LALT   = 3;
	localparam int unsigned MB_CAPS   = 4;
	localparam int unsigned MB_RCTRL  = 5;
	localparam int unsigned MB_RALT   = 6;

	localparam logic [7:0] SC_NULL      = 8'h00;
	localparam logic [7:0] SC_OVERRUN   = 8'hE1;
	localparam logic [7:0] SC_EXT       = 8'hE0;
	localparam logic [7:0] SC_LSHIFT_MK = 8'h2A;
	localparam logic [7:0] SC_RSHIFT_MK = 8'h36;
	localparam logic [7:0] SC_CTRL_MK   = 8'h1D;
	localparam logic [7:0] SC_ALT_MK    = 8'h38;
	localparam logic [7:0] SC_CAPS_MK   = 8'h3A;
	localparam logic [7:0] SC_LSHIFT_BK = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_BK = 8'hB6;
	localparam logic [7:0] SC_CTRL_BK   = 8'h9D;
	localparam logic [7:0] SC_ALT_BK    = 8'hB8;
	localparam logic [7:0] SC_UP        = 8'h48;
	localparam logic [7:0] SC_DOWN      = 8'h50;
	localparam logic [7:0] SC_LEFT      = 8'h4B;
	localparam logic [7:0] SC_RIGHT     = 8'h4D;

	typedef struct packed {
		logic [MODS_W-1:0] mods;
		logic              ext_pending;
	} sc1kd_state_t;

	typedef struct packed {
		logic [KIND_W-1:0] key_kind;
		logic [CHAR_W-1:0] key_char;
		logic [MODS_W-1:0] modifiers;
	} sc1kd_key_t;

	function automatic logic caps_applies(input logic [7:0] code);
		return (code >= 8'h10 && code <= 8'h19) || (code >= 8'h1E && code <= 8'h26) ||
			(code >= 8'h2C && code <= 8'h32);
	endfunction

	function automatic logic [CHAR_W-1:0] plain_char(input logic [6:0] code);
		logic [CHAR_W-1:0] c;
		unique case (code)
			7'h02: c = 7'h31;
			7'h03: c = 7'h32;
			7'h04: c = 7'h33;
			7'h05: c = 7'h34;
			7'h06: c = 7'h35;
			7'h07: c = 7'h36;
			7'h08: c = 7'h37;
			7'h09: c = 7'h38;
			7'h0A: c = 7'h39;
			7'h0B: c = 7'h30;
			7'h0C: c = 7'h2D;
			7'h0D: c = 7'h3D;
			7'h0E: c = 7'h08;
			7'h10: c = 7'h71;
			7'h11: c = 7'h77;
			7'h12: c = 7'h65;
			7'h13: c = 7'h72;
			7'h14: c = 7'h74;
			7'h15: c = 7'h79;
			7'h16: c = 7'h75;
			7'h17: c = 7'h69;
			7'h18: c = 7'h6F;
			7'h19: c = 7'h70;
			7'h1A: c = 7'h5B;
			7'h1B: c = 7'h5D;
			7'h1C: c = 7'h0A;
			7'h1E: c = 7'h61;
			7'h1F: c = 7'h73;
			7'h20: c = 7'h64;
			7'h21: c = 7'h66;
			7'h22: c = 7'h67;
			7'h23: c = 7'h68;
			7'h24: c = 7'h6A;
			7'h25: c = 7'h6B;
			7'h26: c = 7'h6C;
			7'h27: c = 7'h3B;
			7'h28: c = 7'h27;
			7'h29: c = 7'h60;
			7'h2B: c = 7'h5C;
			7'h2C: c = 7'h7A;
			7'h2D: c = 7'h78;
			7'h2E: c = 7'h63;
			7'h2F: c = 7'h76;
			7'h30: c = 7'h62;
			7'h31: c = 7'h6E;
			7'h32: c = 7'h6D;
			7'h33: c = 7'h2C;
			7'h34: c = 7'h2E;
			7'h35: c = 7'h2F;
			7'h37: c = 7'h2A;
			7'h39: c = 7'h20;
			7'h4A: c = 7'h2D;
			7'h4E: c = 7'h2B;
			default: c = '0;
		endcase
		return c;
	endfunction

	function automatic logic [CHAR_W-1:0] upper_char(input logic [6:0] code);
		logic [CHAR_W-1:0] c;
		unique case (code)
			7'h02: c = 7'h21;
			7'h03: c = 7'h40;
			7'h04: c = 7'h23;
			7'h05: c = 7'h24;
			7'h06: c = 7'h25;
			7'h07: c = 7'h5E;
			7'h08: c = 7'h26;
			7'h09: c = 7'h2A;
			7'h0A: c = 7'h28;
			7'h0B: c = 7'h29;
			7'h0C: c = 7'h5F;
			7'h0D: c = 7'h2B;
			7'h10: c = 7'h51;
			7'h11: c = 7'h57;
			7'h12: c = 7'h45;
			7'h13: c = 7'h52;
			7'h14: c = 7'h54;
			7'h15: c = 7'h59;
			7'h16: c = 7'h55;
			7'h17: c = 7'h49;
			7'h18: c = 7'h4F;
			7'h19: c = 7'h50;
			7'h1A: c = 7'h7B;
			7'h1B: c = 7'h7D;
			7'h1E: c = 7'h41;
			7'h1F: c = 7'h53;
			7'h20: c = 7'h44;
			7'h21: c = 7'h46;
			7'h22: c = 7'h47;
			7'h23: c = 7'h48;
			7'h24: c = 7'h4A;
			7'h25: c = 7'h4B;
			7'h26: c = 7'h4C;
			7'h27: c = 7'h3A;
			7'h28: c = 7'h22;
			7'h29: c = 7'h7E;
			7'h2B: c = 7'h7C;
			7'h2C: c = 7'h5A;
			7'h2D: c = 7'h58;
			7'h2E: c = 7'h43;
			7'h2F: c = 7'h56;
			7'h30: c = 7'h42;
			7'h31: c = 7'h4E;
			7'h32: c = 7'h4D;
			7'h33: c = 7'h3C;
			7'h34: c = 7'h3E;
			7'h35: c = 7'h3F;
			7'h37: c = 7'h2A;
			7'h39: c = 7'h20;
			7'h4A: c = 7'h2D;
			7'h4E: c = 7'h2B;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

// File: sv/sc1kd_ifs.sv
// request channels of the scan code set 1 key decoder
interface sc1kd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] scan_byte;

	modport source (output valid, output scan_byte, input ready);
	modport sink (input valid, input scan_byte, output ready);
endinterface

interface sc1kd_key_if;
	logic       valid;
	logic       ready;
	logic [2:0] key_kind;
	logic [6:0] key_char;
	logic [6:0] modifiers;

	modport source (output valid, output key_kind, output key_char, output modifiers,
		input ready);
	modport sink (input valid, input key_kind, input key_char, input modifiers,
		output ready);
endinterface

interface sc1kd_cfg_if;
	logic valid;
	logic ready;
	logic key_output_enable;

	modport source (output valid, output key_output_enable, input ready);
	modport sink (input valid, input key_output_enable, output ready);
endinterface

// File: sv/sc1kd_decode.sv
// combinational decode of one scan byte against the current modifier state
module sc1kd_decode (
	input  logic [7:0]                scan_byte,
	input  logic                      enable,
	input  sc1kd_pkg::sc1kd_state_t   cur,
	output sc1kd_pkg::sc1kd_state_t   nxt,
	output sc1kd_pkg::sc1kd_key_t     key
);
	import sc1kd_pkg::*;

	logic              up;
	logic [CHAR_W-1:0] c;
	logic [KIND_W-1:0] kind;
	logic [CHAR_W-1:0] ch;

	always_comb begin
		nxt  = cur;
		kind = KIND_NONE;
		ch   = '0;
		up   = 1'b0;
		c    = '0;
		priority if (scan_byte == SC_NULL || scan_byte == SC_OVERRUN) begin
			nxt = cur;
		end else if (scan_byte == SC_EXT) begin
			nxt.ext_pending = 1'b1;
		end else if (cur.ext_pending) begin
			nxt.ext_pending = 1'b0;
			unique case (scan_byte)
				SC_CTRL_BK: nxt.mods[MB_RCTRL] = 1'b0;
				SC_ALT_BK:  nxt.mods[MB_RALT] = 1'b0;
				SC_CTRL_MK: nxt.mods[MB_RCTRL] = 1'b1;
				SC_ALT_MK:  nxt.mods[MB_RALT] = 1'b1;
				SC_UP:      kind = KIND_UP;
				SC_DOWN:    kind = KIND_DOWN;
				SC_LEFT:    kind = KIND_LEFT;
				SC_RIGHT:   kind = KIND_RIGHT;
				default:    kind = KIND_NONE;
			endcase
		end else if (scan_byte[7]) begin
			unique case (scan_byte)
				SC_LSHIFT_BK: nxt.mods[MB_LSHIFT] = 1'b0;
				SC_RSHIFT_BK: nxt.mods[MB_RSHIFT] = 1'b0;
				SC_CTRL_BK:   nxt.mods[MB_LCTRL] = 1'b0;
				SC_ALT_BK:    nxt.mods[MB_LALT] = 1'b0;
				default:      nxt.mods = cur.mods;
			endcase
		end else begin
			unique case (scan_byte)
				SC_LSHIFT_MK: nxt.mods[MB_LSHIFT] = 1'b1;
				SC_RSHIFT_MK: nxt.mods[MB_RSHIFT] = 1'b1;
				SC_CTRL_MK:   nxt.mods[MB_LCTRL] = 1'b1;
				SC_ALT_MK:    nxt.mods[MB_LALT] = 1'b1;
				SC_CAPS_MK:   nxt.mods[MB_CAPS] = ~cur.mods[MB_CAPS];
				default:      nxt.mods = cur.mods;
			endcase
			// caps lock flips shift for letters only
			up = (nxt.mods[MB_LSHIFT] | nxt.mods[MB_RSHIFT]) ^
				(caps_applies(scan_byte) & nxt.mods[MB_CAPS]);
			c = up ? upper_char(scan_byte[6:0]) : plain_char(scan_byte[6:0]);
			if (c != '0) begin
				kind = KIND_CHAR;
				ch   = c;
			end
		end
		key.key_kind  = enable ? kind : KIND_NONE;
		key.key_char  = enable ? ch : '0;
		key.modifiers = nxt.mods;
	end

endmodule

// File: sv/scancode_set1_key_decoder_top.sv
// top level of the scan code set 1 key decoder
// usage:
//   scan carries one raw set 1 byte per request from the keyboard data port
//   key returns exactly one result per byte: key kind, ascii char and the
//     modifier snapshot after the byte is applied
//   cfg writes key_output_enable; with it low kind and char read zero while
//     modifier tracking goes on; cfg is always ready, write it only when idle
// the result is registered and sits in the output register the cycle after
//   the byte is taken
// throughput: one byte per cycle while key takes each result; decode and state
//   update are one pass of table lookup and bit logic between the state
//   registers and the output register
// stall: while key is held off the output register keeps its result and scan
//   ready drops; a byte is still taken in the same cycle the waiting result
//   leaves
// reset: modifiers, the pending 0xe0 prefix, the enable bit and the output
//   valid are cleared
module scancode_set1_key_decoder_top (
	input logic          clk,
	input logic          arst_n,
	sc1kd_byte_if.sink   scan,
	sc1kd_key_if.source  key,
	sc1kd_cfg_if.sink    cfg
);
	import sc1kd_pkg::*;

	sc1kd_state_t state_q;
	sc1kd_state_t state_nxt;
	sc1kd_key_t   key_nxt;
	sc1kd_key_t   key_q;
	logic         valid_q;
	logic         enable_q;
	logic         take;

	assign scan.ready = ~valid_q | key.ready;
	assign take       = scan.valid & scan.ready;
	assign cfg.ready  = 1'b1;

	sc1kd_decode u_decode (
		.scan_byte (scan.scan_byte),
		.enable    (enable_q),
		.cur       (state_q),
		.nxt       (state_nxt),
		.key       (key_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_q  <= 1'b0;
			enable_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				enable_q <= cfg.key_output_enable;
			end
			if (take) begin
				state_q <= state_nxt;
				valid_q <= 1'b1;
			end else if (key.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			key_q <= key_nxt;
		end
	end

	assign key.valid     = valid_q;
	assign key.key_kind  = key_q.key_kind;
	assign key.key_char  = key_q.key_char;
	assign key.modifiers = key_q.modifiers;

endmodule

// File: tb/tb_scancode_set1_key_decoder_top.sv
// self-checking testbench of the scan code set 1 key decoder with a keymap scoreboard
`timescale 1ns / 100ps

import sc1kd_pkg::*;

class sc1_keymap_board;
	logic [MODS_W-1:0] mods;
	logic              ext_pending;
	logic              enable;
	logic [CHAR_W-1:0] lower_map[128];
	logic [CHAR_W-1:0] shift_map[128];
	sc1kd_key_t        pending_keys[$];
	int                errors;

	function new();
		string lo;
		string hi;
		byte   c;
		lo = {"##1234567890-=##", "qwertyuiop[]##as", "dfghjkl;'`#\\zxcv",
			"bnm,./#*# ######", "##########-###+#"};
		hi = {"..!@#$%^&*()_+..", "QWERTYUIOP{}..AS", "DFGHJKL:\"~.|ZXCV",
			"BNM<>?.*. ......", "..........-...+."};
		mods = '0;
		ext_pending = 1'b0;
		enable = 1'b0;
		errors = 0;
		for (int i = 0; i < 128; i++) begin
			lower_map[i] = '0;
			shift_map[i] = '0;
		end
		for (int i = 0; i < 80; i++) begin
			c = lo[i];
			if (c != "#") begin
				lower_map[i] = c[6:0];
			end
			c = hi[i];
			if (c != ".") begin
				shift_map[i] = c[6:0];
			end
		end
		// backspace and enter have no printable form
		lower_map[8'h0E] = 7'h08;
		lower_map[8'h1C] = 7'h0A;
	endfunction

	function bit letter_key(logic [7:0] b);
		return (b >= 8'h10 && b <= 8'h19) || (b >= 8'h1E && b <= 8'h26) ||
			(b >= 8'h2C && b <= 8'h32);
	endfunction

	task report(string what, logic [16:0] want, logic [16:0] got);
		if (errors < 40) begin
			$display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
		end
		errors++;
	endtask

	function void note_byte(logic [7:0] b);
		sc1kd_key_t       k;
		logic             up;
		logic [CHAR_W-1:0] ch;
		k = '0;
		if (b == SC_NULL || b == SC_OVERRUN) begin
		end else if (b == SC_EXT) begin
			ext_pending = 1'b1;
		end else if (ext_pending) begin
			ext_pending = 1'b0;
			case (b)
				SC_CTRL_BK: mods[MB_RCTRL] = 1'b0;
				SC_ALT_BK: mods[MB_RALT] = 1'b0;
				SC_CTRL_MK: mods[MB_RCTRL] = 1'b1;
				SC_ALT_MK: mods[MB_RALT] = 1'b1;
				SC_UP: k.key_kind = KIND_UP;
				SC_DOWN: k.key_kind = KIND_DOWN;
				SC_LEFT: k.key_kind = KIND_LEFT;
				SC_RIGHT: k.key_kind = KIND_RIGHT;
				default: ;
			endcase
		end else if (b[7]) begin
			case (b)
				SC_LSHIFT_BK: mods[MB_LSHIFT] = 1'b0;
				SC_RSHIFT_BK: mods[MB_RSHIFT] = 1'b0;
				SC_CTRL_BK: mods[MB_LCTRL] = 1'b0;
				SC_ALT_BK: mods[MB_LALT] = 1'b0;
				default: ;
			endcase
		end else begin
			case (b)
				SC_LSHIFT_MK: mods[MB_LSHIFT] = 1'b1;
				SC_RSHIFT_MK: mods[MB_RSHIFT] = 1'b1;
				SC_CTRL_MK: mods[MB_LCTRL] = 1'b1;
				SC_ALT_MK: mods[MB_LALT] = 1'b1;
				SC_CAPS_MK: mods[MB_CAPS] = ~mods[MB_CAPS];
				default: ;
			endcase
			up = mods[MB_LSHIFT] | mods[MB_RSHIFT];
			if (letter_key(b) && mods[MB_CAPS]) begin
				up = ~up;
			end
			ch = up ? shift_map[b[6:0]] : lower_map[b[6:0]];
			if (ch != '0) begin
				k.key_kind = KIND_CHAR;
				k.key_char = ch;
			end
		end
		if (!enable) begin
			k.key_kind = KIND_NONE;
			k.key_char = '0;
		end
		k.modifiers = mods;
		pending_keys.push_back(k);
	endfunction

	task check_key(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] ch, logic [MODS_W-1:0] m);
		sc1kd_key_t want;
		if (pending_keys.size() == 0) begin
			report("key with no byte pending", '0, {kind, ch, m});
		end else begin
			want = pending_keys.pop_front();
			if (kind !== want.key_kind) begin
				report("key_kind", 17'(want.key_kind), 17'(kind));
			end
			if (ch !== want.key_char) begin
				report("key_char", 17'(want.key_char), 17'(ch));
			end
			if (m !== want.modifiers) begin
				report("modifiers", 17'(want.modifiers), 17'(m));
			end
		end
	endtask
endclass

module tb_scancode_set1_key_decoder_top;
	logic clk;
	logic arst_n;

	sc1kd_byte_if scan_ch();
	sc1kd_key_if  key_ch();
	sc1kd_cfg_if  cfg_ch();

	scancode_set1_key_decoder_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.scan(scan_ch),
		.key(key_ch),
		.cfg(cfg_ch)
	);

	sc1_keymap_board keys;
	int              send_idle_pct;
	int              key_stall_pct;
	int              hold_left;
	int              bytes_taken;

	logic [7:0] directed_bytes[24] = '{SC_NULL, 8'hFF, 8'h80, 8'h7F, 8'h1E, 8'h0E,
		SC_LSHIFT_MK, 8'h35, SC_CAPS_MK, 8'h1E, SC_LSHIFT_BK, 8'h1E, 8'h02, SC_CAPS_MK,
		SC_CTRL_MK, SC_CTRL_BK, SC_EXT, SC_OVERRUN, SC_EXT, SC_UP, SC_EXT, SC_ALT_MK,
		SC_EXT, SC_ALT_BK};
	logic [7:0] mod_codes[8] = '{SC_LSHIFT_MK, SC_RSHIFT_MK, SC_CTRL_MK, SC_ALT_MK,
		SC_LSHIFT_BK, SC_RSHIFT_BK, SC_CTRL_BK, SC_ALT_BK};
	logic [7:0] ext_codes[8] = '{SC_UP, SC_DOWN, SC_LEFT, SC_RIGHT, SC_CTRL_MK, SC_ALT_MK,
		SC_CTRL_BK, SC_ALT_BK};

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	// long receiver hold-off, counted down here
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
			end
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			key_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= key_stall_pct);
			@(posedge clk);
			if (key_ch.valid && key_ch.ready) begin
				keys.check_key(key_ch.key_kind, key_ch.key_char, key_ch.modifiers);
			end
		end
	end

	task automatic offer_scan_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			scan_ch.valid <= 1'b0;
			@(posedge clk);
		end
		scan_ch.valid <= 1'b1;
		scan_ch.scan_byte <= b;
		do @(posedge clk); while (!scan_ch.ready);
		keys.note_byte(b);
		bytes_taken++;
	endtask

	task automatic wait_for_keys();
		do @(posedge clk); while (keys.pending_keys.size() != 0);
	endtask

	task automatic write_output_enable(input logic v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.key_output_enable <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		keys.enable = v;
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic typing_burst();
		logic [7:0] mk;
		int         pick;
		pick = $urandom_range(99);
		mk = 8'($urandom_range(8'h58, 8'h01));
		if (pick < 40) begin
			offer_scan_byte(mk);
			if ($urandom_range(3) != 0) begin
				offer_scan_byte(mk | 8'h80);
			end
		end else if (pick < 55) begin
			offer_scan_byte(mod_codes[$urandom_range(7)]);
		end else if (pick < 62) begin
			offer_scan_byte(SC_CAPS_MK);
		end else if (pick < 80) begin
			offer_scan_byte(SC_EXT);
			case ($urandom_range(5))
				0: offer_scan_byte(SC_EXT);
				1: offer_scan_byte($urandom_range(1) ? SC_NULL : SC_OVERRUN);
				default: ;
			endcase
			if ($urandom_range(4) == 0) begin
				offer_scan_byte(8'($urandom_range(255)));
			end else begin
				offer_scan_byte(ext_codes[$urandom_range(7)]);
			end
		end else if (pick < 88) begin
			offer_scan_byte($urandom_range(1) ? SC_NULL : SC_OVERRUN);
		end else begin
			offer_scan_byte(8'($urandom_range(255)));
		end
	endtask

	task automatic run_phase(input int idle, input int stall, input int count);
		send_idle_pct = idle;
		key_stall_pct = stall;
		bytes_taken = 0;
		while (bytes_taken < count) begin
			typing_burst();
		end
		scan_ch.valid <= 1'b0;
		wait_for_keys();
	endtask

	initial begin
		keys = new();
		send_idle_pct = 0;
		key_stall_pct = 0;
		hold_left = 0;
		bytes_taken = 0;
		arst_n = 1'b0;
		scan_ch.valid = 1'b0;
		scan_ch.scan_byte = '0;
		key_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.key_output_enable = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_output_enable(1'b1);
		foreach (directed_bytes[i]) begin
			offer_scan_byte(directed_bytes[i]);
		end
		scan_ch.valid <= 1'b0;
		wait_for_keys();

		run_phase(0, 0, 350);
		run_phase(83, 0, 350);
		write_output_enable(1'b0);
		run_phase(0, 83, 350);
		write_output_enable(1'b1);
		run_phase(34, 34, 350);
		hold_left = 400;
		run_phase(0, 0, 350);

		repeat (4) @(posedge clk);
		if (keys.pending_keys.size() != 0) begin
			keys.report("keys never returned", '0, 17'(keys.pending_keys.size()));
		end
		if (keys.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

// File: sim.f
sv/sc1kd_pkg.sv
sv/sc1kd_ifs.sv
sv/sc1kd_decode.sv
sv/scancode_set1_key_decoder_top.sv
tb/tb_scancode_set1_key_decoder_top.sv
